[hdl/sequence_median_assert.svh]
// assertion macros for the sequence median rtl
// expects clk_i and rst_ni in the scope of the including module
`ifndef SEQUENCE_MEDIAN_ASSERT_SVH
`define SEQUENCE_MEDIAN_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SQM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SQM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sqm_pkg.sv]
// shared types and constants for the sequence median block
// no dependencies
package sqm_pkg;

  localparam int unsigned MAX_SAMPLES = 64;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned MED_W       = 17;
  localparam int unsigned CNT_OUT_W   = 7;
  localparam int unsigned CNT_W       = $clog2(MAX_SAMPLES + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MED_W-1:0]    median_t;
  typedef logic [CNT_W-1:0]           count_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;    // insert the incoming sample in order
    logic shift;  // move every value one place toward the head
  } chain_ctrl_t;

endpackage

[hdl/sequence_median.sv]
// Median of a flagged sequence of signed 16-bit samples. Samples are sorted on arrival
// by a row of MAX_SAMPLES cells (each inserted in order as it is accepted, one sample per
// cycle while a sequence runs). Samples past the row depth are dropped and flagged as
// overflow. On the sample that carries last, the row shifts toward its head until the
// middle value(s) reach the first two cells, then the head cells are added into the output
// word; the next word is taken only after that, and later while the previous result
// still waits. The result is the median times two (one fractional bit), with the kept
// count and the overflow flag. The output register lets new words enter while a result
// still waits.
// depends on sqm_pkg, sqm_chain, sqm_cell and sequence_median_assert.svh
module sequence_median (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  sqm_pkg::sample_t          sample_i,
  input  logic                      last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output sqm_pkg::median_t          median_half_o,
  output logic [sqm_pkg::CNT_OUT_W-1:0] sample_count_o,
  output logic                      overflow_o
);
  import sqm_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic        state_q, state_d;
  count_t      kept_q, kept_d;
  logic        drop_q, drop_d;
  count_t      left_q, left_d;
  logic        out_valid_q, out_valid_d;
  median_t     med_q, med_d;
  logic [CNT_OUT_W-1:0] cnt_q, cnt_d;
  logic        ovf_q, ovf_d;

  chain_ctrl_t ctrl;
  sample_t     head0, head1, addend;
  logic        acc, full, load;
  count_t      n_end, half;

  sqm_chain u_chain (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .sample_i (sample_i),
    .count_i  (kept_q),
    .head0_o  (head0),
    .head1_o  (head1)
  );

  // handshake and chain commands
  assign in_ready_o = (state_q == ST_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign full       = (kept_q == CNT_W'(MAX_SAMPLES));
  assign ctrl.ins   = acc && !full;
  assign ctrl.shift = (state_q == ST_DRAIN) && (left_q != '0);
  assign load       = (state_q == ST_DRAIN) && (left_q == '0) && (!out_valid_q || out_ready_i);

  // count at the end of the sequence and shifts needed to reach the middle
  assign n_end = full ? kept_q : kept_q + count_t'(1);
  assign half  = n_end >> 1;

  // odd count doubles the head, even count adds the two heads
  assign addend = kept_q[0] ? head0 : head1;

  always_comb begin
    state_d     = state_q;
    kept_d      = kept_q;
    drop_d      = drop_q;
    left_d      = left_q;
    out_valid_d = out_valid_q && !out_ready_i;
    med_d       = med_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            kept_d = kept_q + count_t'(1);
          end
          if (last_i) begin
            state_d = ST_DRAIN;
            left_d  = n_end[0] ? half : half - count_t'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (left_q != '0) begin
          left_d = left_q - count_t'(1);
        end else if (load) begin
          med_d       = {head0[SAMPLE_W-1], head0} + {addend[SAMPLE_W-1], addend};
          cnt_d       = CNT_OUT_W'(kept_q);
          ovf_d       = drop_q;
          out_valid_d = 1'b1;
          kept_d      = '0;
          drop_d      = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kept_q      <= '0;
      drop_q      <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kept_q      <= kept_d;
      drop_q      <= drop_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    med_q <= med_d;
    cnt_q <= cnt_d;
    ovf_q <= ovf_d;
  end

  assign out_valid_o    = out_valid_q;
  assign median_half_o  = med_q;
  assign sample_count_o = cnt_q;
  assign overflow_o     = ovf_q;

  `include "sequence_median_assert.svh"

  `SQM_ASSERT_NOW(a_kept_bound, 1'b1, kept_q <= CNT_W'(MAX_SAMPLES), "kept count past depth")
  `SQM_ASSERT_NEXT(a_last_drains, acc && last_i, state_q == ST_DRAIN, "last word not drained")
  `SQM_ASSERT_NOW(a_no_ins_drain, state_q == ST_DRAIN, !ctrl.ins, "insert during drain")
  `SQM_ASSERT_NEXT(a_load_clears, load, out_valid_q && kept_q == '0 && !drop_q, "result not loaded")
  `SQM_ASSERT_NOW(a_drain_nonempty, state_q == ST_DRAIN, kept_q != '0, "drain with empty row")

endmodule

[hdl/sqm_cell.sv]
// one cell of the sorted insertion chain: holds one sample
// depends on sqm_pkg
module sqm_cell (
  input  logic                clk_i,
  input  sqm_pkg::chain_ctrl_t ctrl_i,
  input  sqm_pkg::sample_t    sample_i,
  input  logic                occ_i,
  input  logic                gt_left_i,
  input  sqm_pkg::sample_t    left_i,
  input  sqm_pkg::sample_t    right_i,
  output logic                gt_o,
  output sqm_pkg::sample_t    val_o
);
  import sqm_pkg::*;

  sample_t val_q, val_d;

  // an empty cell counts as greater than any sample
  assign gt_o = !occ_i || (val_q > sample_i);

  // shift loads from the right; else on insert the first greater cell takes the sample, later ones take from the left
  always_comb begin
    val_d = val_q;
    if (ctrl_i.shift) begin
      val_d = right_i;
    end else if (ctrl_i.ins && gt_o) begin
      val_d = gt_left_i ? left_i : sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

[hdl/sqm_chain.sv]
// row of sorting cells, ascending from the head
// depends on sqm_pkg and sqm_cell
module sqm_chain (
  input  logic                clk_i,
  input  sqm_pkg::chain_ctrl_t ctrl_i,
  input  sqm_pkg::sample_t    sample_i,
  input  sqm_pkg::count_t     count_i,
  output sqm_pkg::sample_t    head0_o,
  output sqm_pkg::sample_t    head1_o
);
  import sqm_pkg::*;

  sample_t val  [MAX_SAMPLES];
  sample_t left [MAX_SAMPLES];
  sample_t right[MAX_SAMPLES];
  logic    gt   [MAX_SAMPLES];
  logic    gtl  [MAX_SAMPLES];
  logic    occ  [MAX_SAMPLES];

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    // cells below the kept count are occupied
    assign occ[i] = (count_i > CNT_W'(i));

    // neighbour wiring, head sees nothing greater on its left
    if (i == 0) begin : g_head
      assign left[i] = sample_i;
      assign gtl[i]  = 1'b0;
    end else begin : g_body
      assign left[i] = val[i-1];
      assign gtl[i]  = gt[i-1];
    end
    if (i == MAX_SAMPLES - 1) begin : g_tail
      assign right[i] = val[i];
    end else begin : g_inner
      assign right[i] = val[i+1];
    end

    sqm_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl_i),
      .sample_i  (sample_i),
      .occ_i     (occ[i]),
      .gt_left_i (gtl[i]),
      .left_i    (left[i]),
      .right_i   (right[i]),
      .gt_o      (gt[i]),
      .val_o     (val[i])
    );
  end

  // the two head cells feed the median adder
  assign head0_o = val[0];
  if (MAX_SAMPLES > 1) begin : g_two
    assign head1_o = val[1];
  end else begin : g_one
    assign head1_o = val[0];
  end

endmodule

[bench/tb_sequence_median.sv]
// testbench for sequence_median: directed and random sample sequences with idling on both sides
// holds its own sorted-store predictor in a small scoreboard class
// depends on sqm_pkg and the sequence_median rtl
`timescale 1ns / 1ps

module tb_sequence_median;
  import sqm_pkg::*;

  localparam int unsigned ITEM_TOTAL   = 800;
  localparam int unsigned SETTLE_ITEMS = 100;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned REPORT_MAX   = 10;

  typedef logic [CNT_OUT_W-1:0] cnt_out_t;

  typedef struct {
    median_t  med;
    cnt_out_t cnt;
    logic     ovf;
  } median_res_t;

  // sorted store predictor and queue of awaited medians
  class median_board;
    sample_t     held[MAX_SAMPLES];
    int unsigned held_cnt;
    bit          dropped;
    median_res_t awaited[$];
    int unsigned mismatch_cnt;

    function new();
      held_cnt     = 0;
      dropped      = 1'b0;
      mismatch_cnt = 0;
    endfunction

    // insert one accepted word, and on the last word queue the median
    function void take_word(sample_t s, logic is_last);
      int unsigned pos;
      int unsigned mid;
      int          total;
      median_res_t res;
      if (held_cnt < MAX_SAMPLES) begin
        pos = held_cnt;
        while (pos > 0 && held[pos-1] > s) begin
          held[pos] = held[pos-1];
          pos--;
        end
        held[pos] = s;
        held_cnt++;
      end else begin
        dropped = 1'b1;
      end
      if (is_last) begin
        mid = held_cnt / 2;
        if (held_cnt % 2 == 1) total = 2 * int'(held[mid]);
        else total = int'(held[mid]) + int'(held[mid-1]);
        res.med = total[MED_W-1:0];
        res.cnt = held_cnt[CNT_OUT_W-1:0];
        res.ovf = dropped;
        awaited = {awaited, res};
        held_cnt = 0;
        dropped  = 1'b0;
      end
    endfunction

    // compare one accepted result with the oldest awaited median
    function void check_median(median_t m, cnt_out_t c, logic o);
      median_res_t exp_res;
      if (awaited.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("%0t: unexpected result median_half %0d sample_count %0d overflow %0b",
                   $realtime, m, c, o);
        return;
      end
      exp_res = awaited.pop_front();
      if (m !== exp_res.med || c !== exp_res.cnt || o !== exp_res.ovf) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("%0t: mismatch median_half exp %0d got %0d, sample_count exp %0d got %0d, %s",
                   $realtime, exp_res.med, m, exp_res.cnt, c,
                   $sformatf("overflow exp %0b got %0b", exp_res.ovf, o));
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  sample_t  sample_i;
  logic     last_i;
  logic     out_valid_o;
  logic     out_ready_i;
  median_t  median_half_o;
  cnt_out_t sample_count_o;
  logic     overflow_o;

  median_board board = new();
  bit          settle_phase = 1'b0;
  int unsigned items_sent   = 0;

  sequence_median u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .median_half_o  (median_half_o),
    .sample_count_o (sample_count_o),
    .overflow_o     (overflow_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("sequence_median verification failed");
    $finish;
  end

  // watch both handshakes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        board.check_median(median_half_o, sample_count_o, overflow_o);
      if (in_valid_i && in_ready_o)
        board.take_word(sample_i, last_i);
    end
  end

  // result side back-pressure in random bursts
  initial begin
    int unsigned hold;
    bit          level;
    out_ready_i = 1'b0;
    hold  = 0;
    level = 1'b0;
    forever begin
      @(negedge clk_i);
      if (settle_phase) begin
        out_ready_i <= 1'b1;
      end else begin
        if (hold == 0) begin
          if ($urandom_range(0, 2) == 0) begin
            level = 1'b0;
            hold  = $urandom_range(1, 13);
          end else begin
            level = 1'b1;
            hold  = $urandom_range(1, 30);
          end
        end
        out_ready_i <= level;
        hold--;
      end
    end
  end

  // drive one word, sometimes after an idle burst; called at a falling edge
  task automatic send_word(input sample_t s, input logic is_last);
    if (!settle_phase && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    last_i     <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  // sample picker: full range, a narrow range for duplicates, or the extremes
  function automatic sample_t pick_sample(int unsigned mode);
    case (mode)
      1: pick_sample = sample_t'($signed($urandom_range(0, 8)) - 4);
      2: begin
        case ($urandom_range(0, 4))
          0: pick_sample = 16'sh8000;
          1: pick_sample = 16'sh7fff;
          2: pick_sample = -16'sd1;
          3: pick_sample = '0;
          default: pick_sample = sample_t'($urandom());
        endcase
      end
      default: pick_sample = sample_t'($urandom());
    endcase
  endfunction

  // one whole sequence with the last flag on its final word
  task automatic send_sequence(input int unsigned len);
    int unsigned mode;
    mode = $urandom_range(0, 3);
    if (mode == 3) mode = 0;
    for (int unsigned i = 0; i < len; i++)
      send_word(pick_sample(mode), i == len - 1);
  endtask

  // stimulus
  initial begin
    int unsigned len;
    int unsigned pick;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    sample_i   = '0;
    last_i     = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // single-word sequences at the extremes and at zero
    send_word(16'sh7fff, 1'b1);
    send_word(16'sh8000, 1'b1);
    send_word(16'sh0000, 1'b1);
    // even counts at the extremes of the sum
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh7fff, 1'b1);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh8000, 1'b1);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh8000, 1'b1);
    // odd count, unsorted arrival
    send_word(16'sd5, 1'b0);
    send_word(-16'sd3, 1'b0);
    send_word(16'sd7, 1'b1);
    // descending arrival, every word shifts the store
    send_word(16'sd3, 1'b0);
    send_word(16'sd2, 1'b0);
    send_word(16'sd1, 1'b0);
    send_word(16'sd0, 1'b1);
    // duplicates
    send_word(16'sd1, 1'b0);
    send_word(-16'sd1, 1'b0);
    send_word(16'sd1, 1'b0);
    send_word(-16'sd1, 1'b0);
    send_word(16'sd1, 1'b1);
    // odd sum in half units
    send_word(-16'sd1, 1'b0);
    send_word(16'sd0, 1'b1);

    // overflow by two words, overflow by one with the last word dropped, and exactly full
    send_sequence(66);
    send_sequence(65);
    send_sequence(MAX_SAMPLES);

    // random sequences, mostly short, a few up to and past the store depth
    while (items_sent < ITEM_TOTAL) begin
      if (items_sent + SETTLE_ITEMS >= ITEM_TOTAL) settle_phase = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 70) len = $urandom_range(1, 8);
      else if (pick < 85) len = $urandom_range(9, 40);
      else if (pick < 95) len = $urandom_range(41, MAX_SAMPLES);
      else len = $urandom_range(MAX_SAMPLES + 1, MAX_SAMPLES + 8);
      send_sequence(len);
    end
    in_valid_i <= 1'b0;

    // wait for every awaited median, then let the block settle
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.mismatch_cnt == 0 && board.pending() == 0) begin
      $display("sequence_median verification clean");
    end else begin
      $display("sequence_median verification failed");
    end
    $finish;
  end

endmodule
